### rtl/gbss_pkg.sv
package gbss_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  info_byte;
        logic        flag_bit;
        logic [15:0] word_value;
        logic [7:0]  index_value;
        logic [15:0] frame_total;
        logic [7:0]  aspect_ratio;
        logic        run_end;
    } out_item_t;

    typedef struct packed {
        logic      has_a;
        logic      has_b;
        out_item_t rec_a;
        out_item_t rec_b;
    } rec_pair_t;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_FRAME  = 2'd1;
    localparam logic [1:0] KIND_OK     = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [7:0] BYTE_EXT     = 8'h21;
    localparam logic [7:0] BYTE_IMAGE   = 8'h2c;
    localparam logic [7:0] BYTE_TRAILER = 8'h3b;
    localparam logic [7:0] LABEL_GCE    = 8'hf9;
    localparam logic [7:0] LABEL_COMM   = 8'hfe;
    localparam logic [7:0] LABEL_PTEXT  = 8'h01;
    localparam logic [7:0] LABEL_APP    = 8'hff;
    localparam logic [15:0] MIN_LENGTH_RESET = 16'd381;
    localparam logic [4:0] MATCH_OFF = 5'd31;

    function automatic logic [7:0] sig_byte(input logic [3:0] i);
        case (i)
            4'd0: sig_byte = 8'h47;
            4'd1: sig_byte = 8'h49;
            4'd2: sig_byte = 8'h46;
            4'd3: sig_byte = 8'h38;
            4'd4: sig_byte = 8'h39;
            4'd5: sig_byte = 8'h61;
            default: sig_byte = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] loop_byte(input logic [4:0] i);
        case (i)
            5'd0: loop_byte = 8'h0b;
            5'd1: loop_byte = 8'h4e;
            5'd2: loop_byte = 8'h45;
            5'd3: loop_byte = 8'h54;
            5'd4: loop_byte = 8'h53;
            5'd5: loop_byte = 8'h43;
            5'd6: loop_byte = 8'h41;
            5'd7: loop_byte = 8'h50;
            5'd8: loop_byte = 8'h45;
            5'd9: loop_byte = 8'h32;
            5'd10: loop_byte = 8'h2e;
            5'd11: loop_byte = 8'h30;
            5'd12: loop_byte = 8'h03;
            5'd13: loop_byte = 8'h01;
            default: loop_byte = 8'h00;
        endcase
    endfunction

endpackage

### rtl/gbss_parser.sv
module gbss_parser
    import gbss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] min_length,
    input  logic        item_valid,
    output logic        item_ready,
    input  in_item_t    item,
    output logic        pair_valid,
    input  logic        pair_ready,
    output rec_pair_t   pair
);

    typedef enum logic [4:0] {
        PH_SIG, PH_SCREEN, PH_GTABLE, PH_TOP, PH_LABEL, PH_GCE_LEN, PH_GCE_DATA,
        PH_GCE_SKIP, PH_APP_LEN, PH_APP_SKIP, PH_IMG, PH_LTABLE, PH_LZW_MIN,
        PH_LZW_LEN, PH_LZW_SKIP, PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  fc_reg, fc_next;
    logic [9:0]  skip_reg, skip_next;
    logic [63:0] wh_reg, wh_next;
    logic [7:0]  ph_reg, ph_next;
    logic        ca_reg, ca_next;
    logic [7:0]  cp_reg, cp_next;
    logic [15:0] cd_reg, cd_next;
    logic [7:0]  ct_reg, ct_next;
    logic        lf_reg, lf_next;
    logic [15:0] lv_reg, lv_next;
    logic [4:0]  am_reg, am_next;
    logic        se_reg, se_next;
    logic [15:0] fcnt_reg, fcnt_next;
    logic [15:0] bc_reg, bc_next;
    rec_pair_t   pair_reg, pair_next;
    logic        pv_reg;

    logic [7:0]  b;
    logic        go;
    logic [10:0] tbl_len;

    assign item_ready = !pv_reg || pair_ready;
    assign go         = item_valid && item_ready;
    assign pair_valid = pv_reg;
    assign pair       = pair_reg;
    assign b          = item.in_byte;

    always_comb
    begin
        phase_next = phase_reg;
        fc_next    = fc_reg;
        skip_next  = skip_reg;
        wh_next    = wh_reg;
        ph_next    = ph_reg;
        ca_next    = ca_reg;
        cp_next    = cp_reg;
        cd_next    = cd_reg;
        ct_next    = ct_reg;
        lf_next    = lf_reg;
        lv_next    = lv_reg;
        am_next    = am_reg;
        se_next    = se_reg;
        fcnt_next  = fcnt_reg;
        bc_next    = (bc_reg != 16'hffff) ? bc_reg + 16'd1 : bc_reg;
        pair_next  = '0;
        tbl_len    = '0;

        if (phase_reg == PH_APP_LEN || phase_reg == PH_APP_SKIP)
        begin
            if (am_reg < 5'd14)
                am_next = (b == loop_byte(am_reg)) ? am_reg + 5'd1 : MATCH_OFF;
            else if (am_reg == 5'd14)
            begin
                ph_next = b;
                am_next = 5'd15;
            end
            else if (am_reg == 5'd15)
            begin
                lv_next = {b, ph_reg};
                lf_next = 1'b1;
                am_next = MATCH_OFF;
            end
        end

        case (phase_reg)
            PH_SIG:
            begin
                if (fc_reg > 4'd5 || b != sig_byte(fc_reg))
                begin
                    se_next = 1'b1;
                    phase_next = PH_DONE;
                end
                else if (fc_reg == 4'd5)
                begin
                    fc_next = '0;
                    wh_next = '0;
                    phase_next = PH_SCREEN;
                end
                else
                    fc_next = fc_reg + 4'd1;
            end
            PH_SCREEN:
            begin
                if (fc_reg < 4'd4)
                begin
                    wh_next[8*fc_reg[1:0] +: 8] = b;
                    fc_next = fc_reg + 4'd1;
                end
                else if (fc_reg == 4'd4)
                begin
                    ph_next = b;
                    fc_next = fc_reg + 4'd1;
                end
                else if (fc_reg == 4'd5)
                begin
                    wh_next[39:32] = b;
                    fc_next = fc_reg + 4'd1;
                end
                else
                begin
                    pair_next.has_a = 1'b1;
                    pair_next.rec_a.record_kind = KIND_HEADER;
                    pair_next.rec_a.width = wh_reg[15:0];
                    pair_next.rec_a.height = wh_reg[31:16];
                    pair_next.rec_a.info_byte = ph_reg;
                    pair_next.rec_a.index_value = wh_reg[39:32];
                    pair_next.rec_a.frame_total = fcnt_reg;
                    pair_next.rec_a.aspect_ratio = b;
                    fc_next = '0;
                    if (ph_reg[7])
                    begin
                        tbl_len = 11'd3 << ({1'b0, ph_reg[2:0]} + 4'd1);
                        skip_next = tbl_len[9:0];
                        phase_next = PH_GTABLE;
                    end
                    else
                        phase_next = PH_TOP;
                end
            end
            PH_GTABLE, PH_GCE_SKIP, PH_APP_SKIP, PH_LTABLE, PH_LZW_SKIP:
            begin
                skip_next = (skip_reg != '0) ? skip_reg - 10'd1 : skip_reg;
                if (skip_next == '0)
                begin
                    case (phase_reg)
                        PH_GTABLE:   phase_next = PH_TOP;
                        PH_GCE_SKIP: phase_next = PH_GCE_LEN;
                        PH_APP_SKIP: phase_next = PH_APP_LEN;
                        PH_LTABLE:   phase_next = PH_LZW_MIN;
                        default:     phase_next = PH_LZW_LEN;
                    endcase
                end
            end
            PH_TOP:
            begin
                if (b == BYTE_EXT)
                    phase_next = PH_LABEL;
                else if (b == BYTE_IMAGE)
                begin
                    phase_next = PH_IMG;
                    fc_next = '0;
                    wh_next = '0;
                end
                else if (b == BYTE_TRAILER)
                    phase_next = PH_DONE;
                else if (b != 8'h00)
                    se_next = 1'b1;
            end
            PH_LABEL:
            begin
                if (b == LABEL_GCE)
                    phase_next = PH_GCE_LEN;
                else if (b == LABEL_COMM || b == LABEL_PTEXT || b == LABEL_APP)
                begin
                    am_next = lf_reg ? MATCH_OFF : 5'd0;
                    phase_next = PH_APP_LEN;
                end
                else
                    phase_next = PH_TOP;
            end
            PH_GCE_LEN:
            begin
                if (b == 8'd0)
                    phase_next = PH_TOP;
                else if (b == 8'd4)
                begin
                    ca_next = 1'b1;
                    fc_next = '0;
                    phase_next = PH_GCE_DATA;
                end
                else
                begin
                    skip_next = {2'b00, b};
                    phase_next = PH_GCE_SKIP;
                end
            end
            PH_GCE_DATA:
            begin
                case (fc_reg)
                    4'd0:    cp_next = {3'b000, b[4:0]};
                    4'd1:    cd_next[7:0] = b;
                    4'd2:    cd_next[15:8] = b;
                    default: ct_next = b;
                endcase
                if (fc_reg >= 4'd3)
                begin
                    fc_next = '0;
                    phase_next = PH_GCE_LEN;
                end
                else
                    fc_next = fc_reg + 4'd1;
            end
            PH_APP_LEN:
            begin
                if (b == 8'd0)
                begin
                    am_next = MATCH_OFF;
                    phase_next = PH_TOP;
                end
                else
                begin
                    skip_next = {2'b00, b};
                    phase_next = PH_APP_SKIP;
                end
            end
            PH_IMG:
            begin
                if (fc_reg < 4'd8)
                begin
                    wh_next[8*fc_reg[2:0] +: 8] = b;
                    fc_next = fc_reg + 4'd1;
                end
                else
                begin
                    fc_next = '0;
                    if (b[7])
                    begin
                        tbl_len = 11'd3 << ({1'b0, b[2:0]} + 4'd1);
                        skip_next = tbl_len[9:0];
                        phase_next = PH_LTABLE;
                    end
                    else
                        phase_next = PH_LZW_MIN;
                end
            end
            PH_LZW_MIN: phase_next = PH_LZW_LEN;
            PH_LZW_LEN:
            begin
                if (b == 8'd0)
                begin
                    if (fcnt_reg != 16'hffff)
                        fcnt_next = fcnt_reg + 16'd1;
                    pair_next.has_a = 1'b1;
                    pair_next.rec_a.record_kind = KIND_FRAME;
                    pair_next.rec_a.pos_x = wh_reg[15:0];
                    pair_next.rec_a.pos_y = wh_reg[31:16];
                    pair_next.rec_a.width = wh_reg[47:32];
                    pair_next.rec_a.height = wh_reg[63:48];
                    pair_next.rec_a.frame_total = fcnt_next;
                    if (ca_reg)
                    begin
                        pair_next.rec_a.info_byte = cp_reg;
                        pair_next.rec_a.flag_bit = 1'b1;
                        pair_next.rec_a.word_value = cd_reg;
                        pair_next.rec_a.index_value = ct_reg;
                    end
                    ca_next = 1'b0;
                    phase_next = PH_TOP;
                end
                else
                begin
                    skip_next = {2'b00, b};
                    phase_next = PH_LZW_SKIP;
                end
            end
            default: ;
        endcase

        if (item.last_byte)
        begin
            pair_next.has_b = 1'b1;
            pair_next.rec_b.record_kind =
                (se_next || bc_next < min_length || phase_next == PH_SIG ||
                 phase_next == PH_SCREEN) ? KIND_ERROR : KIND_OK;
            pair_next.rec_b.flag_bit = lf_next;
            pair_next.rec_b.word_value = lv_next;
            pair_next.rec_b.frame_total = fcnt_next;
            pair_next.rec_b.run_end = 1'b1;
        end
        else
            pair_next.rec_a.run_end = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIG;
            fc_reg    <= '0;
            skip_reg  <= '0;
            wh_reg    <= '0;
            ph_reg    <= '0;
            ca_reg    <= 1'b0;
            cp_reg    <= '0;
            cd_reg    <= '0;
            ct_reg    <= '0;
            lf_reg    <= 1'b0;
            lv_reg    <= '0;
            am_reg    <= '0;
            se_reg    <= 1'b0;
            fcnt_reg  <= '0;
            bc_reg    <= '0;
            pv_reg    <= 1'b0;
            pair_reg  <= '0;
        end
        else
        begin
            if (go)
            begin
                pv_reg   <= pair_next.has_a || pair_next.has_b;
                pair_reg <= pair_next;
                if (item.last_byte)
                begin
                    phase_reg <= PH_SIG;
                    fc_reg    <= '0;
                    skip_reg  <= '0;
                    wh_reg    <= '0;
                    ph_reg    <= '0;
                    ca_reg    <= 1'b0;
                    cp_reg    <= '0;
                    cd_reg    <= '0;
                    ct_reg    <= '0;
                    lf_reg    <= 1'b0;
                    lv_reg    <= '0;
                    am_reg    <= '0;
                    se_reg    <= 1'b0;
                    fcnt_reg  <= '0;
                    bc_reg    <= '0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    fc_reg    <= fc_next;
                    skip_reg  <= skip_next;
                    wh_reg    <= wh_next;
                    ph_reg    <= ph_next;
                    ca_reg    <= ca_next;
                    cp_reg    <= cp_next;
                    cd_reg    <= cd_next;
                    ct_reg    <= ct_next;
                    lf_reg    <= lf_next;
                    lv_reg    <= lv_next;
                    am_reg    <= am_next;
                    se_reg    <= se_next;
                    fcnt_reg  <= fcnt_next;
                    bc_reg    <= bc_next;
                end
            end
            else if (pair_ready)
                pv_reg <= 1'b0;
        end
    end

endmodule

### rtl/gbss_emitter.sv
module gbss_emitter
    import gbss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pair_valid,
    output logic      pair_ready,
    input  rec_pair_t pair,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int Depth = 2;

    rec_pair_t  q_mem [Depth];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    logic       sub_reg;
    logic       push, pop, done;
    rec_pair_t  head;

    assign head       = q_mem[rp_reg];
    assign pair_ready = cnt_reg != 2'd2;
    assign push       = pair_valid && pair_ready;
    assign out_valid  = cnt_reg != 2'd0;
    assign out_item   = (sub_reg || !head.has_a) ? head.rec_b : head.rec_a;

    always_comb
    begin
        done = out_valid && out_ready &&
               (sub_reg || !head.has_a || !head.has_b);
    end
    assign pop = done;

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wp_reg] <= pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            sub_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
            begin
                rp_reg  <= !rp_reg;
                sub_reg <= 1'b0;
            end
            else if (out_valid && out_ready)
                sub_reg <= 1'b1;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### rtl/gif_block_structure_scanner.sv
// channel  | signals                        | payload
// input    | in_valid / in_ready            | in_item  (in_item_t)
// output   | out_valid / out_ready          | out_item (out_item_t)
// config   | min_length_we                  | min_length_wdata
// one byte per cycle unless the output stalls; a byte that yields two records
// holds its queue entry until the one-record-per-cycle output port takes both
// parser registers records the cycle after the byte; two-entry queue to output
// rst_n clears all but queue storage asynchronously, min_length resets to 381
// output stalls back up through the queue into in_ready
module gif_block_structure_scanner
    import gbss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        min_length_we,
    input  logic [15:0] min_length_wdata
);

    logic [15:0] min_length_reg;
    logic        pair_valid, pair_ready;
    rec_pair_t   pair;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_length_reg <= MIN_LENGTH_RESET;
        else if (min_length_we)
            min_length_reg <= min_length_wdata;
    end

    gbss_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .min_length (min_length_reg),
        .item_valid (in_valid),
        .item_ready (in_ready),
        .item       (in_item),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair)
    );

    gbss_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import gbss_pkg::*;

    localparam int PERIOD_NS = 12;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 600;

    typedef enum logic [4:0] {
        P_SIG, P_SCREEN, P_GTABLE, P_TOP, P_LABEL, P_GCE_LEN, P_GCE_DATA, P_GCE_SKIP,
        P_APP_LEN, P_APP_SKIP, P_IMG, P_LTABLE, P_LZW_MIN, P_LZW_LEN, P_LZW_SKIP, P_DONE
    } scan_phase_e;

    typedef struct {
        logic [7:0]  b;
        logic        last;
        logic        check_kind;
        logic [1:0]  kind;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;
    logic        min_length_we;
    logic [15:0] min_length_wdata;

    // predictor state
    logic [15:0] cur_min_length;
    scan_phase_e ph;
    logic [3:0]  fcnt;
    logic [9:0]  skip_left;
    logic [63:0] whold;
    logic [7:0]  phold;
    logic        gce_on;
    logic [7:0]  gce_packed;
    logic [15:0] gce_delay;
    logic [7:0]  gce_transp;
    logic        loop_seen;
    logic [15:0] loop_count;
    logic [4:0]  match_pos;
    logic        err_flag;
    logic [15:0] frames;
    logic [15:0] bytes_seen;

    out_item_t   record_queue[$];
    logic [7:0]  byte_queue[$];
    logic        last_queue[$];
    logic        kind_known_queue[$];
    logic [1:0]  kind_queue[$];

    int          errors;
    int          records_seen;
    int          bytes_sent;
    int          idle_cycles;
    bit          allow_idle;
    bit          timed_out;

    gif_block_structure_scanner i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_item          (in_item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_item         (out_item),
        .min_length_we    (min_length_we),
        .min_length_wdata (min_length_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(PERIOD_NS / 2.0) clk = ~clk;
        end
    end

    function automatic logic [7:0] signature_char(int i);
        logic [47:0] s;
        s = 48'h47_49_46_38_39_61;
        return s[47 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] loop_id_char(int i);
        logic [111:0] s;
        s = 112'h0b_4e_45_54_53_43_41_50_45_32_2e_30_03_01;
        return s[111 - 8 * i -: 8];
    endfunction

    task automatic clear_scan();
        ph = P_SIG;
        fcnt = '0;
        skip_left = '0;
        whold = '0;
        phold = '0;
        gce_on = 1'b0;
        gce_packed = '0;
        gce_delay = '0;
        gce_transp = '0;
        loop_seen = 1'b0;
        loop_count = '0;
        match_pos = '0;
        err_flag = 1'b0;
        frames = '0;
        bytes_seen = '0;
    endtask

    function automatic out_item_t make_record(logic [1:0] kind);
        out_item_t r;
        r = '0;
        r.record_kind = kind;
        return r;
    endfunction

    task automatic begin_skip(int count, scan_phase_e skip_ph, scan_phase_e next_ph);
        if (count == 0)
            ph = next_ph;
        else
        begin
            skip_left = count[9:0];
            ph = skip_ph;
        end
    endtask

    task automatic skip_one(scan_phase_e next_ph);
        if (skip_left > 0)
            skip_left = skip_left - 1'b1;
        if (skip_left == 0)
            ph = next_ph;
    endtask

    task automatic track_loop_id(logic [7:0] b);
        if (match_pos < 14)
        begin
            if (b == loop_id_char(match_pos))
                match_pos = match_pos + 1'b1;
            else
                match_pos = MATCH_OFF;
        end
        else if (match_pos == 14)
        begin
            phold = b;
            match_pos = 5'd15;
        end
        else if (match_pos == 15)
        begin
            loop_count = {b, phold};
            loop_seen = 1'b1;
            match_pos = MATCH_OFF;
        end
    endtask

    // expected records for one accepted byte
    task automatic scan_byte(logic [7:0] b, logic last);
        out_item_t recs[$];
        out_item_t r;
        logic bad;
        if (bytes_seen != 16'hffff)
            bytes_seen = bytes_seen + 1'b1;
        case (ph)
            P_SIG:
            begin
                if (fcnt > 5 || b != signature_char(fcnt))
                begin
                    err_flag = 1'b1;
                    ph = P_DONE;
                end
                else if (fcnt == 5)
                begin
                    fcnt = '0;
                    whold = '0;
                    ph = P_SCREEN;
                end
                else
                    fcnt = fcnt + 1'b1;
            end
            P_SCREEN:
            begin
                if (fcnt < 4)
                begin
                    whold[8 * fcnt +: 8] = b;
                    fcnt = fcnt + 1'b1;
                end
                else if (fcnt == 4)
                begin
                    phold = b;
                    fcnt = fcnt + 1'b1;
                end
                else if (fcnt == 5)
                begin
                    whold[39:32] = b;
                    fcnt = fcnt + 1'b1;
                end
                else
                begin
                    r = make_record(KIND_HEADER);
                    r.width = whold[15:0];
                    r.height = whold[31:16];
                    r.info_byte = phold;
                    r.index_value = whold[39:32];
                    r.frame_total = frames;
                    r.aspect_ratio = b;
                    recs.push_back(r);
                    fcnt = '0;
                    if (phold[7])
                        begin_skip(3 << (phold[2:0] + 1), P_GTABLE, P_TOP);
                    else
                        ph = P_TOP;
                end
            end
            P_GTABLE: skip_one(P_TOP);
            P_TOP:
            begin
                if (b == BYTE_EXT)
                    ph = P_LABEL;
                else if (b == BYTE_IMAGE)
                begin
                    ph = P_IMG;
                    fcnt = '0;
                    whold = '0;
                end
                else if (b == BYTE_TRAILER)
                    ph = P_DONE;
                else if (b != 8'h00)
                    err_flag = 1'b1;
            end
            P_LABEL:
            begin
                if (b == LABEL_GCE)
                    ph = P_GCE_LEN;
                else if (b == LABEL_COMM || b == LABEL_PTEXT || b == LABEL_APP)
                begin
                    match_pos = loop_seen ? MATCH_OFF : 5'd0;
                    ph = P_APP_LEN;
                end
                else
                    ph = P_TOP;
            end
            P_GCE_LEN:
            begin
                if (b == 0)
                    ph = P_TOP;
                else if (b == 4)
                begin
                    gce_on = 1'b1;
                    fcnt = '0;
                    ph = P_GCE_DATA;
                end
                else
                    begin_skip(b, P_GCE_SKIP, P_GCE_LEN);
            end
            P_GCE_DATA:
            begin
                if (fcnt == 0)
                    gce_packed = {3'b000, b[4:0]};
                else if (fcnt == 1)
                    gce_delay[7:0] = b;
                else if (fcnt == 2)
                    gce_delay[15:8] = b;
                else
                    gce_transp = b;
                if (fcnt >= 3)
                begin
                    fcnt = '0;
                    ph = P_GCE_LEN;
                end
                else
                    fcnt = fcnt + 1'b1;
            end
            P_GCE_SKIP: skip_one(P_GCE_LEN);
            P_APP_LEN:
            begin
                track_loop_id(b);
                if (b == 0)
                begin
                    match_pos = MATCH_OFF;
                    ph = P_TOP;
                end
                else
                    begin_skip(b, P_APP_SKIP, P_APP_LEN);
            end
            P_APP_SKIP:
            begin
                track_loop_id(b);
                skip_one(P_APP_LEN);
            end
            P_IMG:
            begin
                if (fcnt < 8)
                begin
                    whold[8 * fcnt +: 8] = b;
                    fcnt = fcnt + 1'b1;
                end
                else
                begin
                    fcnt = '0;
                    if (b[7])
                        begin_skip(3 << (b[2:0] + 1), P_LTABLE, P_LZW_MIN);
                    else
                        ph = P_LZW_MIN;
                end
            end
            P_LTABLE: skip_one(P_LZW_MIN);
            P_LZW_MIN: ph = P_LZW_LEN;
            P_LZW_LEN:
            begin
                if (b == 0)
                begin
                    if (frames != 16'hffff)
                        frames = frames + 1'b1;
                    r = make_record(KIND_FRAME);
                    r.pos_x = whold[15:0];
                    r.pos_y = whold[31:16];
                    r.width = whold[47:32];
                    r.height = whold[63:48];
                    r.frame_total = frames;
                    if (gce_on)
                    begin
                        r.info_byte = gce_packed;
                        r.flag_bit = 1'b1;
                        r.word_value = gce_delay;
                        r.index_value = gce_transp;
                    end
                    recs.push_back(r);
                    gce_on = 1'b0;
                    ph = P_TOP;
                end
                else
                    begin_skip(b, P_LZW_SKIP, P_LZW_LEN);
            end
            P_LZW_SKIP: skip_one(P_LZW_LEN);
            default: ;
        endcase
        if (last)
        begin
            bad = err_flag || bytes_seen < cur_min_length || ph == P_SIG || ph == P_SCREEN;
            r = make_record(bad ? KIND_ERROR : KIND_OK);
            r.flag_bit = loop_seen;
            r.word_value = loop_count;
            r.frame_total = frames;
            recs.push_back(r);
            clear_scan();
        end
        if (recs.size() > 0)
            recs[recs.size() - 1].run_end = 1'b1;
        foreach (recs[i])
            record_queue.push_back(recs[i]);
    endtask

    // stimulus builders
    task automatic put(logic [7:0] b, logic last = 1'b0);
        byte_queue.push_back(b);
        last_queue.push_back(last);
        kind_known_queue.push_back(1'b0);
        kind_queue.push_back(KIND_HEADER);
    endtask

    task automatic put_rand_bytes(int n);
        repeat (n) put(8'($urandom_range(0, 255)));
    endtask

    task automatic put_header(logic [7:0] packed_byte);
        for (int i = 0; i < 6; i++)
            put(signature_char(i));
        put_rand_bytes(4);
        put(packed_byte);
        put_rand_bytes(2);
        if (packed_byte[7])
            put_rand_bytes(3 << (packed_byte[2:0] + 1));
    endtask

    task automatic put_gce(int len);
        put(BYTE_EXT);
        put(LABEL_GCE);
        put(8'(len));
        put_rand_bytes(len);
        put(8'h00);
    endtask

    task automatic put_loop_ext(logic [7:0] label, bit broken);
        put(BYTE_EXT);
        put(label);
        for (int i = 0; i < 14; i++)
            put((broken && i == 5) ? 8'h00 : loop_id_char(i));
        put_rand_bytes(2);
        put(8'h00);
    endtask

    task automatic put_image(logic [7:0] local_packed, int blocks);
        put(BYTE_IMAGE);
        put_rand_bytes(8);
        put(local_packed);
        if (local_packed[7])
            put_rand_bytes(3 << (local_packed[2:0] + 1));
        put(8'($urandom_range(2, 8)));
        repeat (blocks)
        begin
            int n;
            n = $urandom_range(1, 20);
            put(8'(n));
            put_rand_bytes(n);
        end
        put(8'h00);
    endtask

    task automatic put_random_stream();
        int n;
        logic [7:0] p;
        p = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0)
            p[2:0] = 3'($urandom_range(0, 2));
        put_header(p);
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0, 1: put_gce(4);
                2: put_gce($urandom_range(1, 9));
                3: put_loop_ext($urandom_range(0, 1) ? LABEL_APP : LABEL_COMM,
                                $urandom_range(0, 3) == 0);
                4: begin put(BYTE_EXT); put(8'($urandom_range(0, 255))); end
                5: put($urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 255)) : 8'h00);
                default:
                begin
                    p = 8'($urandom_range(0, 255));
                    p[2:0] = 3'($urandom_range(0, 1));
                    put_image(p, $urandom_range(0, 3));
                end
            endcase
        end
        if ($urandom_range(0, 4) != 0)
            put(BYTE_TRAILER);
        if ($urandom_range(0, 5) == 0)
            put_rand_bytes($urandom_range(1, 4));
        put(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // directed table: a few rows have their record kind read off directly
    task automatic load_directed();
        stim_row_t rows[$];
        rows.push_back('{8'h00, 1'b1, 1'b1, KIND_ERROR});
        rows.push_back('{8'hff, 1'b1, 1'b1, KIND_ERROR});
        rows.push_back('{8'h47, 1'b0, 1'b0, KIND_HEADER});
        rows.push_back('{8'h00, 1'b0, 1'b0, KIND_HEADER});
        rows.push_back('{8'h00, 1'b1, 1'b1, KIND_ERROR});
        foreach (rows[i])
        begin
            byte_queue.push_back(rows[i].b);
            last_queue.push_back(rows[i].last);
            kind_known_queue.push_back(rows[i].check_kind);
            kind_queue.push_back(rows[i].kind);
        end
        // short stream with header, GCE, loop, image and trailer blocks, extremes in the fields
        for (int i = 0; i < 6; i++)
            put(signature_char(i));
        put(8'hff); put(8'hff); put(8'h00); put(8'h00);
        put(8'h80); put(8'hff); put(8'h00);
        put_rand_bytes(6);
        put_gce(4);
        put_loop_ext(LABEL_APP, 1'b0);
        put(BYTE_EXT); put(8'h55);
        put(8'h00); put(8'h77);
        put_image(8'h81, 2);
        put(BYTE_TRAILER);
        put(8'h12);
        put(8'h3b, 1'b1);
    endtask

    task automatic write_min_length(logic [15:0] v);
        min_length_we <= 1'b1;
        min_length_wdata <= v;
        @(posedge clk);
        min_length_we <= 1'b0;
        cur_min_length = v;
    endtask

    task automatic wait_drained();
        while (record_queue.size() != 0 || byte_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // sender
    initial
    begin
        int gap;
        in_valid = 1'b0;
        in_item = '0;
        min_length_we = 1'b0;
        min_length_wdata = '0;
        rst_n = 1'b0;
        errors = 0;
        records_seen = 0;
        bytes_sent = 0;
        allow_idle = 1'b1;
        timed_out = 1'b0;
        cur_min_length = MIN_LENGTH_RESET;
        clear_scan();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase_no = 0; phase_no < 5; phase_no++)
        begin
            case (phase_no)
                0: ;
                1: write_min_length(16'h0000);
                2: write_min_length(16'hffff);
                3: write_min_length(16'($urandom_range(20, 200)));
                default: write_min_length(16'($urandom_range(0, 60)));
            endcase
            if (phase_no == 0)
                load_directed();
            else
                while (byte_queue.size() < RANDOM_ITEMS / 4)
                    put_random_stream();
            if (phase_no == 4)
                allow_idle = 1'b0;
            while (byte_queue.size() != 0)
            begin
                if (allow_idle && $urandom_range(0, 7) == 0)
                begin
                    gap = $urandom_range(1, 16);
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                in_valid <= 1'b1;
                in_item <= '{in_byte: byte_queue[0], last_byte: last_queue[0]};
                @(posedge clk);
                while (!in_ready)
                    @(posedge clk);
                scan_byte(byte_queue[0], last_queue[0]);
                if (kind_known_queue[0] && record_queue.size() > 0
                    && record_queue[record_queue.size() - 1].record_kind != kind_queue[0])
                begin
                    $error("record_kind for directed row: expected %0d, actual %0d",
                           kind_queue[0], record_queue[record_queue.size() - 1].record_kind);
                    errors++;
                end
                void'(byte_queue.pop_front());
                void'(last_queue.pop_front());
                void'(kind_known_queue.pop_front());
                void'(kind_queue.pop_front());
                bytes_sent++;
            end
            in_valid <= 1'b0;
            wait_drained();
        end
        $display("run covered %0d bytes in streams with five min_length settings", bytes_sent);
        $display("%0d records checked against the scanner prediction", records_seen);
        if (errors == 0 && record_queue.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // receiver with random stall bursts
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (allow_idle && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 16);
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // output checker
    always @(posedge clk)
    begin
        out_item_t exp_rec;
        if (rst_n && out_valid && out_ready)
        begin
            records_seen++;
            if (record_queue.size() == 0)
            begin
                $error("unexpected record: kind %0d", out_item.record_kind);
                errors++;
            end
            else
            begin
                exp_rec = record_queue.pop_front();
                if (out_item.record_kind !== exp_rec.record_kind) begin
                    $error("record_kind: expected %0d, actual %0d",
                           exp_rec.record_kind, out_item.record_kind); errors++; end
                if (out_item.pos_x !== exp_rec.pos_x) begin
                    $error("pos_x: expected %0d, actual %0d",
                           exp_rec.pos_x, out_item.pos_x); errors++; end
                if (out_item.pos_y !== exp_rec.pos_y) begin
                    $error("pos_y: expected %0d, actual %0d",
                           exp_rec.pos_y, out_item.pos_y); errors++; end
                if (out_item.width !== exp_rec.width) begin
                    $error("width: expected %0d, actual %0d",
                           exp_rec.width, out_item.width); errors++; end
                if (out_item.height !== exp_rec.height) begin
                    $error("height: expected %0d, actual %0d",
                           exp_rec.height, out_item.height); errors++; end
                if (out_item.info_byte !== exp_rec.info_byte) begin
                    $error("info_byte: expected %0h, actual %0h",
                           exp_rec.info_byte, out_item.info_byte); errors++; end
                if (out_item.flag_bit !== exp_rec.flag_bit) begin
                    $error("flag_bit: expected %0d, actual %0d",
                           exp_rec.flag_bit, out_item.flag_bit); errors++; end
                if (out_item.word_value !== exp_rec.word_value) begin
                    $error("word_value: expected %0d, actual %0d",
                           exp_rec.word_value, out_item.word_value); errors++; end
                if (out_item.index_value !== exp_rec.index_value) begin
                    $error("index_value: expected %0d, actual %0d",
                           exp_rec.index_value, out_item.index_value); errors++; end
                if (out_item.frame_total !== exp_rec.frame_total) begin
                    $error("frame_total: expected %0d, actual %0d",
                           exp_rec.frame_total, out_item.frame_total); errors++; end
                if (out_item.aspect_ratio !== exp_rec.aspect_ratio) begin
                    $error("aspect_ratio: expected %0d, actual %0d",
                           exp_rec.aspect_ratio, out_item.aspect_ratio); errors++; end
                if (out_item.run_end !== exp_rec.run_end) begin
                    $error("run_end: expected %0d, actual %0d",
                           exp_rec.run_end, out_item.run_end); errors++; end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || min_length_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
